[hdl/assert_macros.svh]
// Assertion macros shared by the decoder RTL.
// Expects signals named clk and rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold cond on every clock edge outside reset.
`define FUPD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Hold cons whenever ante is true.
`define FUPD_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[hdl/fupd_pkg.sv]
// Package for the file URI percent decoder: phase type, run descriptor,
// prefix character table, hex digit decode and queue sizing. No dependencies.
package fupd_pkg;

    localparam int PREFIX_LEN = 7;
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = $clog2(Q_DEPTH);

    localparam logic [7:0] CH_PERCENT = 8'h25;

    typedef enum logic [1:0] {
        PH_PREFIX = 2'd0,
        PH_NORMAL = 2'd1,
        PH_ESC1   = 2'd2,
        PH_ESC2   = 2'd3
    } fupd_phase_t;

    // Results caused by one accepted input word: a run of prefix text,
    // then up to three literal bytes.
    typedef struct packed {
        logic [2:0]      pre_cnt;
        logic [1:0]      tail_cnt;
        logic [2:0][7:0] tail;
        logic            fin;
        logic            empty;
    } fupd_desc_t;

    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h66;
            3'd1:    c = 8'h69;
            3'd2:    c = 8'h6c;
            3'd3:    c = 8'h65;
            3'd4:    c = 8'h3a;
            default: c = 8'h2f;
        endcase
        return c;
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, c[3:0]};
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            r = {1'b1, c[3:0] + 4'd9};
        return r;
    endfunction

endpackage

[hdl/fupd_in_if.sv]
// Input channel of the decoder: valid/ready handshake with one URI text byte.
// No dependencies.
interface fupd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_final;

    modport source (output valid, in_byte, in_final, input ready);
    modport sink   (input valid, in_byte, in_final, output ready);
endinterface

[hdl/fupd_out_if.sv]
// Output channel of the decoder: valid/ready handshake with one path byte.
// No dependencies.
interface fupd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_run_last;
    logic       out_text_end;
    logic       out_empty;

    modport source (output valid, out_byte, out_run_last, out_text_end, out_empty,
                    input ready);
    modport sink   (input valid, out_byte, out_run_last, out_text_end, out_empty,
                    output ready);
endinterface

[hdl/fupd_front.sv]
// Front end: prefix match and escape tracking, at most one descriptor per word.
// Depends on fupd_pkg and fupd_in_if.
module fupd_front (
    input  logic                clk,
    input  logic                rst_n,
    fupd_in_if.sink             text,
    input  logic                q_full,
    output logic                push,
    output fupd_pkg::fupd_desc_t desc
);
    import fupd_pkg::*;

    fupd_phase_t phase_reg, phase_next;
    logic [2:0]  pm_reg, pm_next;
    logic [7:0]  held_reg, held_next;
    logic        emitted_reg, emitted_next;

    logic        accept;
    logic        has_res;
    logic [7:0]  b;
    logic        fin;
    logic [2:0]  m1;
    fupd_phase_t ph_eff;
    logic        do_decode;
    logic [4:0]  hv_hi;
    logic [4:0]  hv_lo;

    assign text.ready = !q_full;
    assign accept     = text.valid && text.ready;
    assign b          = text.in_byte;
    assign fin        = text.in_final;
    assign hv_hi      = hex_val(held_reg);
    assign hv_lo      = hex_val(b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_PREFIX;
            pm_reg      <= 3'd0;
            held_reg    <= 8'd0;
            emitted_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            pm_reg      <= pm_next;
            held_reg    <= held_next;
            emitted_reg <= emitted_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        pm_next      = pm_reg;
        held_next    = held_reg;
        emitted_next = emitted_reg;
        desc         = '0;
        desc.fin     = fin;
        m1           = pm_reg + 3'd1;
        ph_eff       = phase_reg;
        do_decode    = 1'b1;

        if (phase_reg == PH_PREFIX)
        begin
            if ({29'd0, pm_reg} < PREFIX_LEN && b == prefix_char(pm_reg))
            begin
                do_decode = 1'b0;
                if ({29'd0, m1} >= PREFIX_LEN)
                begin
                    phase_next = PH_NORMAL;
                    pm_next    = 3'd0;
                end
                else
                begin
                    pm_next = m1;
                    if (fin)
                        desc.pre_cnt = m1;
                end
            end
            else
            begin
                desc.pre_cnt = pm_reg;
                pm_next      = 3'd0;
                ph_eff       = PH_NORMAL;
            end
        end

        if (do_decode)
        begin
            case (ph_eff)
                PH_ESC1:
                begin
                    held_next  = b;
                    phase_next = PH_ESC2;
                    if (fin)
                    begin
                        desc.tail[0]  = CH_PERCENT;
                        desc.tail[1]  = b;
                        desc.tail_cnt = 2'd2;
                    end
                end
                PH_ESC2:
                begin
                    phase_next = PH_NORMAL;
                    if (hv_hi[4] && hv_lo[4])
                    begin
                        desc.tail[0]  = {hv_hi[3:0], hv_lo[3:0]};
                        desc.tail_cnt = 2'd1;
                    end
                    else
                    begin
                        desc.tail[0]  = CH_PERCENT;
                        desc.tail[1]  = held_reg;
                        desc.tail[2]  = b;
                        desc.tail_cnt = 2'd3;
                    end
                end
                default:
                begin
                    phase_next = PH_NORMAL;
                    if (b == CH_PERCENT)
                    begin
                        phase_next = PH_ESC1;
                        if (fin)
                        begin
                            desc.tail[0]  = CH_PERCENT;
                            desc.tail_cnt = 2'd1;
                        end
                    end
                    else
                    begin
                        desc.tail[0]  = b;
                        desc.tail_cnt = 2'd1;
                    end
                end
            endcase
        end

        if (fin && desc.pre_cnt == 3'd0 && desc.tail_cnt == 2'd0 && !emitted_reg)
        begin
            desc.tail[0]  = 8'd0;
            desc.tail_cnt = 2'd1;
            desc.empty    = 1'b1;
        end

        has_res = (desc.pre_cnt != 3'd0) || (desc.tail_cnt != 2'd0);
        push    = accept && has_res;

        if (has_res)
            emitted_next = 1'b1;

        if (fin)
        begin
            phase_next   = PH_PREFIX;
            pm_next      = 3'd0;
            held_next    = 8'd0;
            emitted_next = 1'b0;
        end

        if (!accept)
        begin
            phase_next   = phase_reg;
            pm_next      = pm_reg;
            held_next    = held_reg;
            emitted_next = emitted_reg;
        end
    end

endmodule

[hdl/fupd_queue.sv]
// Descriptor queue between front and back end, register storage.
// Depends on fupd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fupd_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  fupd_pkg::fupd_desc_t wr_desc,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output fupd_pkg::fupd_desc_t head
);
    import fupd_pkg::*;

    fupd_desc_t      mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]   count_reg, count_next;

    assign full       = count_reg == Q_AW'(0) + (Q_AW+1)'(Q_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_desc;
    end

    `FUPD_ASSERT_IMPLIES(a_no_push_full, full, !push, "push into a full queue")
    `FUPD_ASSERT_IMPLIES(a_no_pop_empty, !head_valid, !pop, "pop from an empty queue")

endmodule

[hdl/fupd_back.sv]
// Back end: expands one descriptor into path bytes, output register.
// Depends on fupd_pkg, fupd_out_if and assert_macros.svh.
`include "assert_macros.svh"
module fupd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  fupd_pkg::fupd_desc_t head,
    output logic                 pop,
    fupd_out_if.source           path
);
    import fupd_pkg::*;

    logic [2:0] k_reg, k_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       run_last_reg, text_end_reg, empty_reg;

    logic       load;
    logic       last;
    logic [3:0] total;
    logic [1:0] t_idx;

    always_comb
    begin
        total = {1'b0, head.pre_cnt} + {2'b00, head.tail_cnt};
        last  = ({1'b0, k_reg} + 4'd1) == total;
        load  = head_valid && (!valid_reg || path.ready);
        pop   = load && last;
        t_idx = 2'(k_reg - head.pre_cnt);
        if (k_reg < head.pre_cnt)
            byte_next = prefix_char(k_reg);
        else
            byte_next = head.tail[t_idx];
        k_next = k_reg;
        if (load)
            k_next = last ? 3'd0 : k_reg + 3'd1;
        if (load)
            valid_next = 1'b1;
        else if (path.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg     <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            k_reg     <= k_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg     <= byte_next;
            run_last_reg <= last;
            text_end_reg <= last && head.fin;
            empty_reg    <= head.empty;
        end
    end

    assign path.valid        = valid_reg;
    assign path.out_byte     = byte_reg;
    assign path.out_run_last = run_last_reg;
    assign path.out_text_end = text_end_reg;
    assign path.out_empty    = empty_reg;

    `FUPD_ASSERT_IMPLIES(a_end_is_last, valid_reg && text_end_reg, run_last_reg,
                         "text end on a word that is not the last of its run")
    `FUPD_ASSERT_IMPLIES(a_empty_ends, valid_reg && empty_reg, text_end_reg,
                         "empty result that does not end the text")
    `FUPD_ASSERT_IMPLIES(a_idx_in_run, head_valid, {1'b0, k_reg} < total,
                         "run index beyond the descriptor length")

endmodule

[hdl/file_uri_percent_decoder.sv]
// A result word reaches the sink through the descriptor queue and then the output register.
// Throughput: one input word per cycle while the four-entry descriptor queue has room;
// one result word per cycle while the sink is ready; a descriptor is popped with its last result word.
// The output register is the only stage facing the sink; the queue decouples the input.
// Reset (asynchronous, active low) empties the queue and output and restarts prefix match.
// Depends on fupd_pkg, fupd_in_if, fupd_out_if, fupd_front, fupd_queue, fupd_back.
module file_uri_percent_decoder (
    input  logic       clk,
    input  logic       rst_n,
    fupd_in_if.sink    text,
    fupd_out_if.source path
);
    import fupd_pkg::*;

    fupd_desc_t f_desc;
    fupd_desc_t q_head;
    logic       f_push;
    logic       q_full;
    logic       q_head_valid;
    logic       b_pop;

    fupd_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text),
        .q_full (q_full),
        .push   (f_push),
        .desc   (f_desc)
    );

    fupd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (f_push),
        .wr_desc    (f_desc),
        .full       (q_full),
        .pop        (b_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    fupd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (b_pop),
        .path       (path)
    );

endmodule

[verif/tb.sv]
// Self-checking bench for file_uri_percent_decoder: streams URI texts in and
// checks every decoded path word against a built-in model of the decoder.
// Depends on fupd_pkg, fupd_in_if, fupd_out_if and the decoder RTL.
module tb;
    import fupd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_WORDS = 450;
    localparam int HOLD_AT = 380;
    localparam int HOLD_CYCLES = 60;
    localparam logic [0:6][7:0] URI_SCHEME = "file://";

    typedef struct packed {
        logic [7:0] b;
        logic       fin;
    } uri_word_t;

    typedef struct packed {
        logic [7:0] b;
        logic       run_last;
        logic       text_end;
        logic       empty;
    } path_word_t;

    logic clk;
    logic rst_n;

    fupd_in_if  text_if ();
    fupd_out_if path_if ();

    file_uri_percent_decoder u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text_if),
        .path  (path_if)
    );

    uri_word_t  uri_words[$];
    path_word_t path_expected[$];
    logic [7:0] run_bytes[$];

    fupd_phase_t scan_phase;
    logic [2:0]  scheme_hits;
    logic [7:0]  held_digit;
    logic        path_started;

    uri_word_t  next_word;
    path_word_t got;
    path_word_t want;
    logic       text_took;
    logic       sink_hold;
    int         words_taken;
    int         texts_taken;
    int         path_words;
    int         empty_paths;
    int         burst_len;
    int         longest_burst;
    int         faults;
    int         cycle_count;

    function automatic logic hex_digit(input logic [7:0] c, output logic [3:0] v);
        v = 4'h0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c[3:0];
            return 1'b1;
        end
        if (c >= 8'h41 && c <= 8'h46)
        begin
            v = 4'(c - 8'h37);
            return 1'b1;
        end
        if (c >= 8'h61 && c <= 8'h66)
        begin
            v = 4'(c - 8'h57);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void add_run_byte(input logic [7:0] b);
        run_bytes = {run_bytes, b};
    endfunction

    function automatic void decode_char(input logic [7:0] b);
        logic [3:0] hi;
        logic [3:0] lo;
        logic       hi_ok;
        logic       lo_ok;
        case (scan_phase)
            PH_ESC1:
            begin
                held_digit = b;
                scan_phase = PH_ESC2;
            end
            PH_ESC2:
            begin
                hi_ok = hex_digit(held_digit, hi);
                lo_ok = hex_digit(b, lo);
                if (hi_ok && lo_ok)
                    add_run_byte({hi, lo});
                else
                begin
                    add_run_byte(CH_PERCENT);
                    add_run_byte(held_digit);
                    add_run_byte(b);
                end
                scan_phase = PH_NORMAL;
            end
            default:
            begin
                if (b == CH_PERCENT)
                    scan_phase = PH_ESC1;
                else
                    add_run_byte(b);
            end
        endcase
    endfunction

    function automatic void restart_scan();
        scan_phase   = PH_PREFIX;
        scheme_hits  = 3'd0;
        held_digit   = 8'h00;
        path_started = 1'b0;
    endfunction

    function automatic void predict_path(input logic [7:0] b, input logic fin);
        logic       empty;
        path_word_t w;
        empty = 1'b0;
        run_bytes.delete();
        if (scan_phase == PH_PREFIX)
        begin
            if (b == URI_SCHEME[scheme_hits])
            begin
                if (scheme_hits == 3'd6)
                begin
                    scan_phase  = PH_NORMAL;
                    scheme_hits = 3'd0;
                end
                else
                    scheme_hits = scheme_hits + 3'd1;
            end
            else
            begin
                for (int i = 0; i < int'(scheme_hits); i++)
                    add_run_byte(URI_SCHEME[i]);
                scheme_hits = 3'd0;
                scan_phase  = PH_NORMAL;
                decode_char(b);
            end
        end
        else
            decode_char(b);

        if (fin)
        begin
            case (scan_phase)
                PH_PREFIX:
                    for (int i = 0; i < int'(scheme_hits); i++)
                        add_run_byte(URI_SCHEME[i]);
                PH_ESC1:
                    add_run_byte(CH_PERCENT);
                PH_ESC2:
                begin
                    add_run_byte(CH_PERCENT);
                    add_run_byte(held_digit);
                end
                default: ;
            endcase
            if (run_bytes.size() == 0 && !path_started)
            begin
                empty = 1'b1;
                add_run_byte(8'h00);
            end
        end

        foreach (run_bytes[k])
        begin
            w.b        = run_bytes[k];
            w.run_last = (k == run_bytes.size() - 1);
            w.text_end = w.run_last && fin;
            w.empty    = empty;
            path_expected = {path_expected, w};
        end
        if (run_bytes.size() > 0)
            path_started = 1'b1;
        if (fin)
            restart_scan();
    endfunction

    function automatic void add_word(input logic [7:0] b, input logic fin);
        uri_word_t w;
        w.b   = b;
        w.fin = fin;
        uri_words = {uri_words, w};
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_word(s[i], i == s.len() - 1);
    endfunction

    function automatic logic [7:0] hex_char();
        logic [3:0] v;
        v = 4'($urandom_range(15));
        if (v < 4'd10)
            return 8'h30 + {4'h0, v};
        if ($urandom_range(1))
            return 8'h37 + {4'h0, v};
        return 8'h57 + {4'h0, v};
    endfunction

    function automatic void add_random_text();
        logic [7:0] body[$];
        int kind;
        int n;
        int r;
        kind = $urandom_range(99);
        if (kind < 75)
            n = 7;
        else if (kind < 90)
            n = $urandom_range(1, 6);
        else
            n = 0;
        for (int i = 0; i < n; i++)
            body = {body, URI_SCHEME[i]};
        repeat ($urandom_range(0, 8))
        begin
            r = $urandom_range(99);
            if (r < 30)
                body = {body, 8'($urandom_range(255))};
            else if (r < 50)
                body = {body, 8'($urandom_range(8'h21, 8'h7e))};
            else if (r < 72)
            begin
                body = {body, CH_PERCENT};
                body = {body, hex_char()};
                body = {body, hex_char()};
            end
            else if (r < 82)
            begin
                body = {body, CH_PERCENT};
                body = {body, 8'($urandom_range(255))};
                body = {body, 8'($urandom_range(255))};
            end
            else if (r < 90)
            begin
                body = {body, CH_PERCENT};
                body = {body, CH_PERCENT};
                body = {body, hex_char()};
            end
            else
                body = {body, 8'h2f};
        end
        r = $urandom_range(9);
        if (r < 2)
            body = {body, CH_PERCENT};
        if (r == 1)
            body = {body, hex_char()};
        if (body.size() == 0)
            body = {body, 8'($urandom_range(255))};
        foreach (body[i])
            add_word(body[i], i == body.size() - 1);
    endfunction

    function automatic int idle_pct(input logic for_sender);
        if (words_taken < 160)
            return for_sender ? 30 : 54;
        if (words_taken < 320)
            return for_sender ? 54 : 30;
        return 0;
    endfunction

    task automatic note_fault(input string what, input path_word_t w, input path_word_t g);
        faults++;
        if (faults <= 10)
            $display("tb: %s: expected %h/%b/%b/%b, got %h/%b/%b/%b (byte/run/end/empty)",
                     what, w.b, w.run_last, w.text_end, w.empty,
                     g.b, g.run_last, g.text_end, g.empty);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        int start;
        rst_n            = 1'b0;
        text_if.valid    = 1'b0;
        text_if.in_byte  = 8'h00;
        text_if.in_final = 1'b0;
        path_if.ready    = 1'b0;
        restart_scan();

        add_text("file://");
        add_text("fil");
        add_text("file:/%");
        add_text("%4A%%z%");
        add_word(8'h00, 1'b0);
        add_word(8'hff, 1'b0);
        add_word(CH_PERCENT, 1'b0);
        add_word(8'h45, 1'b1);
        start = uri_words.size();
        while (uri_words.size() - start < RANDOM_WORDS)
            add_random_text();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (uri_words.size() != 0 || text_if.valid)
            @(posedge clk);
        while (path_expected.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (path_expected.size() != 0)
            faults++;

        $display("tb: %0d texts, %0d text bytes, %0d path bytes, %0d empty paths",
                 texts_taken, words_taken, path_words, empty_paths);
        $display("tb: longest burst %0d; idling swapped sides, then stopped; one sink hold-off",
                 longest_burst);
        if (faults == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // hold off the sink while the sender keeps offering
    initial
    begin
        sink_hold = 1'b0;
        wait (words_taken >= HOLD_AT);
        @(negedge clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        sink_hold <= 1'b0;
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            text_if.valid <= 1'b0;
        else if (!text_if.valid || text_took)
        begin
            if (uri_words.size() > 0 && $urandom_range(99) >= idle_pct(1'b1))
            begin
                next_word = uri_words.pop_front();
                text_if.in_byte  <= next_word.b;
                text_if.in_final <= next_word.fin;
                text_if.valid    <= 1'b1;
            end
            else
                text_if.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            path_if.ready <= 1'b0;
        else
            path_if.ready <= !sink_hold && ($urandom_range(99) >= idle_pct(1'b0));
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            text_took <= 1'b0;
        else
        begin
            text_took <= text_if.valid && text_if.ready;
            if (text_if.valid && text_if.ready)
            begin
                predict_path(text_if.in_byte, text_if.in_final);
                words_taken++;
                if (text_if.in_final)
                    texts_taken++;
            end
            if (path_if.valid && path_if.ready)
            begin
                got = {path_if.out_byte, path_if.out_run_last,
                       path_if.out_text_end, path_if.out_empty};
                path_words++;
                burst_len++;
                if (burst_len > longest_burst)
                    longest_burst = burst_len;
                if (got.run_last)
                    burst_len = 0;
                if (got.empty)
                    empty_paths++;
                if (path_expected.size() == 0)
                    note_fault("path word with nothing expected", '0, got);
                else
                begin
                    want = path_expected.pop_front();
                    if (got.run_last !== want.run_last || got.text_end !== want.text_end ||
                        got.empty !== want.empty || (!want.empty && got.b !== want.b))
                        note_fault("path word mismatch", want, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule

[files.f]
+incdir+hdl
hdl/fupd_pkg.sv
hdl/fupd_in_if.sv
hdl/fupd_out_if.sv
hdl/fupd_front.sv
hdl/fupd_queue.sv
hdl/fupd_back.sv
hdl/file_uri_percent_decoder.sv
verif/tb.sv
